[src/double_ended_queue_macros.svh]
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication, checked outside reset.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

[src/dq_pkg.sv]
// Types and constants shared by the double-ended queue.
package dq_pkg;

  localparam int unsigned DefaultDepth     = 16;
  localparam int unsigned DefaultDataWidth = 32;
  localparam int unsigned OutW             = 32;
  localparam int unsigned CountW           = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic signed [31:0]  front_value;
    logic signed [31:0]  rear_value;
    logic                is_empty;
    logic                is_full;
    logic [CountW-1:0]   entry_count;
  } rsp_t;

endpackage

[src/double_ended_queue.sv]
// Double-ended queue of signed words kept in a ring-buffer memory.
//
//  channel   direction  handshake           payload
//  request   in         start && !busy      req_i  (dq_pkg::req_t)
//  result    out        done_o, one cycle   rsp_o  (dq_pkg::rsp_t)
//
// One request per cycle; its result appears with done_o on the next cycle.
// busy stays low: the memory write and both end reads happen at the
// accepting edge, and a push's own word is forwarded over the stale read.
// Reset clears head pointer and occupancy; the slot memory is not cleared.
// The receiver cannot stall, so no result is ever held back.
module double_ended_queue #(
  parameter int unsigned DEPTH      = dq_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = dq_pkg::DefaultDataWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  dq_pkg::req_t req_i,
  output logic         done_o,
  output dq_pkg::rsp_t rsp_o
);
  import dq_pkg::*;

  `include "double_ended_queue_macros.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
    return r[AW-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] occ_q, occ_d;

  logic                  accept;
  logic                  is_push, full_now, empty_now, push_ok, pop_ok;
  logic [AW-1:0]         head_dec, head_inc, waddr, rear_addr;
  logic [SW-1:0]         rear_sum;
  logic                  we;
  logic [DATA_WIDTH-1:0] word_in;

  logic                  done_q;
  status_e               status_q;
  logic                  empty_q, full_q, fwd_front_q, fwd_rear_q;
  logic [CW-1:0]         count_q;
  logic [DATA_WIDTH-1:0] word_q, rd_front_q, rd_rear_q;
  logic [DATA_WIDTH-1:0] front_word, rear_word;
  logic [OutW-1:0]       front_ext, rear_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Take the low DATA_WIDTH bits of the value, sign-extend when wider.
  if (DATA_WIDTH <= OutW) begin : g_in_narrow
    assign word_in = req_i.value[DATA_WIDTH-1:0];
  end else begin : g_in_wide
    assign word_in = {{(DATA_WIDTH-OutW){req_i.value[OutW-1]}}, req_i.value};
  end

  always_comb begin
    is_push   = (req_i.cmd == CMD_PUSH_FRONT) || (req_i.cmd == CMD_PUSH_REAR);
    full_now  = (occ_q == CW'(DEPTH));
    empty_now = (occ_q == '0);
    push_ok   = is_push && !full_now;
    pop_ok    = !is_push && !empty_now;
    head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
    head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

    head_d = head_q;
    occ_d  = occ_q;
    waddr  = head_dec;
    if (push_ok) begin
      occ_d = occ_q + CW'(1);
      if (req_i.cmd == CMD_PUSH_FRONT) begin
        head_d = head_dec;
      end else begin
        waddr = wrap_idx({1'b0, head_q} + SW'(occ_q));
      end
    end else if (pop_ok) begin
      occ_d = occ_q - CW'(1);
      if (req_i.cmd == CMD_POP_FRONT) begin
        head_d = head_inc;
      end
    end
    we = accept && push_ok;

    // Rear sits at head + count - 1; any slot will do when empty.
    rear_sum  = (occ_d == '0) ? '0 : ({1'b0, head_d} + SW'(occ_d) - SW'(1));
    rear_addr = wrap_idx(rear_sum);
  end

  // Slot memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= word_in;
    end
    if (accept) begin
      rd_front_q <= mem[head_d];
      rd_rear_q  <= mem[rear_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        head_q <= head_d;
        occ_q  <= occ_d;
      end
    end
  end

  // Result payload, captured with the request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= is_push ? (full_now ? ST_FULL : ST_DONE)
                             : (empty_now ? ST_EMPTY : ST_DONE);
      empty_q     <= (occ_d == '0);
      full_q      <= (occ_d == CW'(DEPTH));
      count_q     <= occ_d;
      word_q      <= word_in;
      // The memory read returns the old word where this push writes.
      fwd_front_q <= push_ok && ((req_i.cmd == CMD_PUSH_FRONT) || (occ_d == CW'(1)));
      fwd_rear_q  <= push_ok && ((req_i.cmd == CMD_PUSH_REAR) || (occ_d == CW'(1)));
    end
  end

  assign front_word = fwd_front_q ? word_q : rd_front_q;
  assign rear_word  = fwd_rear_q  ? word_q : rd_rear_q;

  if (DATA_WIDTH >= OutW) begin : g_out_wide
    assign front_ext = front_word[OutW-1:0];
    assign rear_ext  = rear_word[OutW-1:0];
  end else begin : g_out_narrow
    assign front_ext = {{(OutW-DATA_WIDTH){front_word[DATA_WIDTH-1]}}, front_word};
    assign rear_ext  = {{(OutW-DATA_WIDTH){rear_word[DATA_WIDTH-1]}}, rear_word};
  end

  always_comb begin
    rsp_o.status      = status_q;
    rsp_o.front_value = empty_q ? '1 : front_ext;
    rsp_o.rear_value  = empty_q ? '1 : rear_ext;
    rsp_o.is_empty    = empty_q;
    rsp_o.is_full     = full_q;
    rsp_o.entry_count = CountW'(count_q);
  end

  assign done_o = done_q;

  `DQ_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, accept, done_o)
  `DQ_ASSERT_NOW(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= CW'(DEPTH))
  `DQ_ASSERT_NOW(a_head_bound, clk_i, rst_ni, 1'b1, head_q <= AW'(DEPTH - 1))
  `DQ_ASSERT_NEXT(a_full_push_holds, clk_i, rst_ni,
                  accept && is_push && full_now,
                  occ_q == CW'(DEPTH) && rsp_o.status == ST_FULL)
  `DQ_ASSERT_NOW(a_count_flags, clk_i, rst_ni, done_o,
                 rsp_o.is_empty == (count_q == '0))

endmodule
